FILE: hdl/bfi_pkg.sv
`default_nettype none

package bfi_pkg;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 8;
  localparam int DATA_W      = 64;
  localparam int START_W     = 14;
  localparam int COUNT_W     = 15;
  localparam int FUNC_W      = 2;
  localparam int HI_W        = 16;
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_RANGE = 2'd2
  } bfi_action_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_KEEP   = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_SET    = 2'd2,
    FN_INVERT = 2'd3
  } bfi_func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_SETUP,
    ST_RD_FIRST,
    ST_RMW,
    ST_RD_WAIT,
    ST_DONE
  } bfi_state_t;

  typedef struct packed {
    logic latch;
    logic clr_wr;
    logic word_wr;
    logic word_rd;
    logic setup;
    logic rd_cur;
    logic rmw_wr;
    logic rd_next;
    logic advance;
    logic set_err;
    logic cap_read;
    logic load_out;
  } bfi_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                idx_ok;
    logic                range_err;
    logic                range_nop;
    logic                clr_last;
    logic                more_words;
  } bfi_status_t;

endpackage

`default_nettype wire

FILE: hdl/bfi_in_if.sv
`default_nettype none

interface bfi_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfi_pkg::ACTION_W-1:0]   action;
  logic [bfi_pkg::INDEX_W-1:0]    word_index;
  logic [bfi_pkg::DATA_W-1:0]     word_data;
  logic [bfi_pkg::START_W-1:0]    bit_start;
  logic [bfi_pkg::COUNT_W-1:0]    bit_count;
  logic [bfi_pkg::FUNC_W-1:0]     func;

  modport source (
    output valid, action, word_index, word_data, bit_start, bit_count, func,
    input  ready
  );

  modport sink (
    input  valid, action, word_index, word_data, bit_start, bit_count, func,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/bfi_out_if.sv
`default_nettype none

interface bfi_out_if;
  logic                         valid;
  logic                         ready;
  logic [bfi_pkg::DATA_W-1:0]   read_data;
  logic                         range_error;

  modport source (
    output valid, read_data, range_error,
    input  ready
  );

  modport sink (
    input  valid, read_data, range_error,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/bit_range_fill_invert_unit.sv
// from accept to result valid: a word write, an unused action, an empty range or a
// rejected range go from decode straight to done; an in-range word read passes through
// a read-wait state; a range touching n words goes through multiply, setup and first
// read, then one read-modify-write per word on the one memory instance; one transaction
// at a time: the next is taken in the cycle after the last enters the output register
// reset clears the control state and then sweeps every word of the store to zero
`default_nettype none

module bit_range_fill_invert_unit #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  bfi_in_if.sink   in_ch,
  bfi_out_if.source out_ch
);

  import bfi_pkg::*;

  bfi_cmd_t    cmd;
  bfi_status_t sts;
  logic        in_ready;
  logic        out_valid;

  bfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfi_datapath #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_word_index   (in_ch.word_index),
    .in_word_data    (in_ch.word_data),
    .in_bit_start    (in_ch.bit_start),
    .in_bit_count    (in_ch.bit_count),
    .in_func         (in_ch.func),
    .out_read_data   (out_ch.read_data),
    .out_range_error (out_ch.range_error)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

FILE: hdl/bfi_ram.sv
`default_nettype none

module bfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bfi_ctrl.sv
`default_nettype none

module bfi_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire bfi_pkg::bfi_status_t sts,
  output      bfi_pkg::bfi_cmd_t    cmd
);

  import bfi_pkg::*;

  bfi_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.advance = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        unique case (sts.action)
          ACT_WRITE: cmd.word_wr = sts.idx_ok;
          ACT_READ: begin
            if (sts.idx_ok) begin
              cmd.word_rd = 1'b1;
              state_nxt   = ST_RD_WAIT;
            end
          end
          ACT_RANGE: begin
            if (sts.range_err) begin
              cmd.set_err = 1'b1;
            end else if (!sts.range_nop) begin
              state_nxt = ST_MUL;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_MUL: state_nxt = ST_SETUP;
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RD_FIRST;
      end
      ST_RD_FIRST: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = ST_RMW;
      end
      ST_RMW: begin
        cmd.rmw_wr = 1'b1;
        if (sts.more_words) begin
          cmd.rd_next = 1'b1;
          cmd.advance = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        cmd.cap_read = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/bfi_datapath.sv
`default_nettype none

module bfi_datapath #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bfi_pkg::bfi_cmd_t            cmd,
  output      bfi_pkg::bfi_status_t         sts,
  input  wire logic [bfi_pkg::ACTION_W-1:0] in_action,
  input  wire logic [bfi_pkg::INDEX_W-1:0]  in_word_index,
  input  wire logic [bfi_pkg::DATA_W-1:0]   in_word_data,
  input  wire logic [bfi_pkg::START_W-1:0]  in_bit_start,
  input  wire logic [bfi_pkg::COUNT_W-1:0]  in_bit_count,
  input  wire logic [bfi_pkg::FUNC_W-1:0]   in_func,
  output      logic [bfi_pkg::DATA_W-1:0]   out_read_data,
  output      logic                         out_range_error
);

  import bfi_pkg::*;

  localparam int ADDR_W  = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W   = $clog2(WORD_BITS + 1);
  localparam int TOTAL   = WORD_COUNT * WORD_BITS;
  localparam int TOT_W   = $clog2(TOTAL + 1);
  localparam int CMP_W   = (TOT_W > HI_W ? TOT_W : HI_W) + 1;
  localparam int IDX_CW  = $clog2(WORD_COUNT + 1) + 1;
  localparam int RECIP   = (1 << RECIP_SHIFT) / WORD_BITS;
  localparam int RECIP_W = RECIP_SHIFT - 2;
  localparam int PROD_W  = START_W + RECIP_W;
  localparam int Q_W     = PROD_W - RECIP_SHIFT;
  localparam int MUL_W   = Q_W + BIT_W;

  logic [ACTION_W-1:0]  action_r;
  logic [INDEX_W-1:0]   index_r;
  logic [WORD_BITS-1:0] data_r;
  logic [START_W-1:0]   start_r;
  logic [HI_W-1:0]      hi_r;
  logic [FUNC_W-1:0]    func_r;
  logic                 nop_r;

  logic [Q_W-1:0]       q_est_r;
  logic [START_W-1:0]   prod_r;
  logic [ADDR_W-1:0]    idx_r;
  logic [HI_W-1:0]      base_r;

  logic [WORD_BITS-1:0] res_data_r;
  logic                 res_err_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_err_r;

  logic [PROD_W-1:0]    recip_prod;
  logic [MUL_W-1:0]     mul_prod;
  logic [START_W-1:0]   rem;
  logic                 corr;
  logic [HI_W-1:0]      lead;
  logic [HI_W-1:0]      span;
  logic [BIT_W-1:0]     lo_a;
  logic [BIT_W-1:0]     lo_b;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rmw_data;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_r <= in_action;
      index_r  <= in_word_index;
      data_r   <= in_word_data[WORD_BITS-1:0];
      start_r  <= in_bit_start;
      hi_r     <= HI_W'(in_bit_start) + HI_W'(in_bit_count);
      func_r   <= in_func;
      nop_r    <= (in_bit_count == '0) || (in_func == FN_KEEP);
    end
  end

  // first word of the range by reciprocal multiply and one correction step
  assign recip_prod = PROD_W'(start_r) * PROD_W'(RECIP);
  assign mul_prod   = MUL_W'(q_est_r) * MUL_W'(WORD_BITS);
  assign rem        = start_r - prod_r;
  assign corr       = rem >= START_W'(WORD_BITS);

  always_ff @(posedge clk) begin
    q_est_r <= recip_prod[PROD_W-1:RECIP_SHIFT];
    prod_r  <= START_W'(mul_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      base_r <= '0;
    end else if (cmd.setup) begin
      idx_r  <= ADDR_W'({1'b0, q_est_r} + (Q_W + 1)'(corr));
      base_r <= HI_W'(prod_r) + (corr ? HI_W'(WORD_BITS) : '0);
    end else if (cmd.advance) begin
      idx_r  <= idx_r + 1'b1;
      base_r <= base_r + HI_W'(WORD_BITS);
    end
  end

  // per-word mask
  assign lead = HI_W'(start_r) - base_r;
  assign span = hi_r - base_r;
  assign lo_a = (HI_W'(start_r) > base_r) ? BIT_W'(lead) : '0;
  assign lo_b = (span >= HI_W'(WORD_BITS)) ? BIT_W'(WORD_BITS) : BIT_W'(span);
  assign ones = '1;
  assign mask = (ones << lo_a) & ~(ones << lo_b);

  always_comb begin
    unique case (func_r)
      FN_CLEAR:  rmw_data = ram_rdata & ~mask;
      FN_SET:    rmw_data = ram_rdata | mask;
      FN_INVERT: rmw_data = ram_rdata ^ mask;
      default:   rmw_data = ram_rdata;
    endcase
  end

  // memory port selection
  always_comb begin
    ram_we    = cmd.clr_wr || cmd.word_wr || cmd.rmw_wr;
    ram_re    = cmd.word_rd || cmd.rd_cur || cmd.rd_next;
    priority if (cmd.clr_wr) begin
      ram_waddr = idx_r;
      ram_wdata = '0;
    end else if (cmd.word_wr) begin
      ram_waddr = ADDR_W'(index_r);
      ram_wdata = data_r;
    end else begin
      ram_waddr = idx_r;
      ram_wdata = rmw_data;
    end
    priority if (cmd.word_rd) begin
      ram_raddr = ADDR_W'(index_r);
    end else if (cmd.rd_next) begin
      ram_raddr = idx_r + 1'b1;
    end else begin
      ram_raddr = idx_r;
    end
  end

  bfi_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_data_r <= '0;
      res_err_r  <= 1'b0;
    end else begin
      if (cmd.cap_read) begin
        res_data_r <= ram_rdata;
      end
      if (cmd.set_err) begin
        res_err_r <= 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_data_r <= DATA_W'(res_data_r);
      out_err_r  <= res_err_r;
    end
  end

  assign out_read_data   = out_data_r;
  assign out_range_error = out_err_r;

  always_comb begin
    sts            = '0;
    sts.action     = action_r;
    sts.idx_ok     = IDX_CW'(index_r) < IDX_CW'(WORD_COUNT);
    sts.range_err  = CMP_W'(hi_r) > CMP_W'(TOTAL);
    sts.range_nop  = nop_r;
    sts.clr_last   = idx_r == ADDR_W'(WORD_COUNT - 1);
    sts.more_words = (HI_W + 1)'(base_r) + (HI_W + 1)'(WORD_BITS) < (HI_W + 1)'(hi_r);
  end

endmodule

`default_nettype wire

FILE: dv/tb_bit_range_fill_invert_unit.sv
`timescale 1ns / 1ps

module tb_bit_range_fill_invert_unit;
  import bfi_pkg::*;

  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = 256;
  localparam int ARRAY_BITS = WORD_BITS * WORD_COUNT;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  word_index;
    logic [DATA_W-1:0]   word_data;
    logic [START_W-1:0]  bit_start;
    logic [COUNT_W-1:0]  bit_count;
    logic [FUNC_W-1:0]   func;
  } bit_op_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              range_error;
  } op_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bfi_in_if  in_ch ();
  bfi_out_if out_ch ();

  bit_range_fill_invert_unit #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [DATA_W-1:0] bitmap_words [WORD_COUNT];
  op_result_t        pending_results [$];
  op_result_t        oldest_result;
  int unsigned       fail_count = 0;
  bit                steady_flow = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] ones_below(int n);
    if (n >= WORD_BITS) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // mirror of the bitmap: updates the store and gives the result of one transaction
  function automatic op_result_t apply_bit_op(bit_op_t op);
    op_result_t        r;
    int                lo;
    int                hi;
    int                base;
    int                a;
    int                b;
    logic [DATA_W-1:0] m;
    r.read_data   = '0;
    r.range_error = 1'b0;
    lo = int'(op.bit_start);
    hi = lo + int'(op.bit_count);
    if (op.action == ACT_WRITE) begin
      bitmap_words[op.word_index] = op.word_data;
    end else if (op.action == ACT_READ) begin
      r.read_data = bitmap_words[op.word_index];
    end else if (op.action == ACT_RANGE) begin
      if (hi > ARRAY_BITS) begin
        r.range_error = 1'b1;
      end else if (op.bit_count != 0 && op.func != FN_KEEP) begin
        for (int w = lo / WORD_BITS; w < WORD_COUNT && w * WORD_BITS < hi; w++) begin
          base = w * WORD_BITS;
          a = (lo > base) ? lo - base : 0;
          b = (hi - base >= WORD_BITS) ? WORD_BITS : hi - base;
          m = ones_below(b) & ~ones_below(a);
          case (op.func)
            FN_CLEAR: bitmap_words[w] = bitmap_words[w] & ~m;
            FN_SET:   bitmap_words[w] = bitmap_words[w] | m;
            default:  bitmap_words[w] = bitmap_words[w] ^ m;
          endcase
        end
      end
    end
    return r;
  endfunction

  function automatic bit_op_t random_fields();
    bit_op_t op;
    op.action     = ACT_UNUSED;
    op.word_index = INDEX_W'($urandom);
    op.word_data  = {$urandom, $urandom};
    op.bit_start  = START_W'($urandom);
    op.bit_count  = COUNT_W'($urandom_range(0, ARRAY_BITS));
    op.func       = FUNC_W'($urandom);
    return op;
  endfunction

  task automatic send_item(bit_op_t op);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.action     = op.action;
    in_ch.word_index = op.word_index;
    in_ch.word_data  = op.word_data;
    in_ch.bit_start  = op.bit_start;
    in_ch.bit_count  = op.bit_count;
    in_ch.func       = op.func;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(apply_bit_op(op));
  endtask

  task automatic send_write(int idx, logic [DATA_W-1:0] data);
    bit_op_t op;
    op = random_fields();
    op.action     = ACT_WRITE;
    op.word_index = INDEX_W'(idx);
    op.word_data  = data;
    send_item(op);
  endtask

  task automatic send_read(int idx);
    bit_op_t op;
    op = random_fields();
    op.action     = ACT_READ;
    op.word_index = INDEX_W'(idx);
    send_item(op);
  endtask

  task automatic send_range(int start, int count, logic [FUNC_W-1:0] fn);
    bit_op_t op;
    op = random_fields();
    op.action    = ACT_RANGE;
    op.bit_start = START_W'(start);
    op.bit_count = COUNT_W'(count);
    op.func      = fn;
    send_item(op);
  endtask

  task automatic test_word_access();
    send_write(0, '1);
    send_write(WORD_COUNT - 1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_write(1, 64'h5555_5555_5555_5555);
    send_read(0);
    send_read(WORD_COUNT - 1);
    send_read(1);
    send_read(17);
  endtask

  task automatic test_range_functions();
    send_range(3, 10, FN_SET);
    send_range(5, 4, FN_CLEAR);
    send_range(60, 10, FN_INVERT);
    send_range(0, 70, FN_KEEP);
    send_read(0);
    send_read(1);
    send_range(0, ARRAY_BITS, FN_SET);
    send_range(100, 1000, FN_INVERT);
    send_read(2);
    send_range(0, ARRAY_BITS, FN_CLEAR);
    send_read(WORD_COUNT - 1);
  endtask

  task automatic test_range_limits();
    send_range(ARRAY_BITS - 1, 2, FN_SET);
    send_range(1, ARRAY_BITS, FN_INVERT);
    send_range(ARRAY_BITS - 1, 0, FN_SET);
    send_range(ARRAY_BITS - 1, 1, FN_SET);
    send_read(WORD_COUNT - 1);
  endtask

  task automatic test_unused_action();
    bit_op_t op;
    op = random_fields();
    send_item(op);
    op = random_fields();
    send_item(op);
  endtask

  task automatic test_random_mix(int n_items);
    bit_op_t op;
    int      pick;
    int      start;
    int      count;
    for (int i = 0; i < n_items; i++) begin
      steady_flow = (i >= 200 && i < 400) || (i >= 1200 && i < 1300);
      op   = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        op.action = ACT_WRITE;
      end else if (pick < 58) begin
        op.action = ACT_READ;
      end else if (pick < 95) begin
        op.action = ACT_RANGE;
        pick  = $urandom_range(0, 99);
        start = $urandom_range(0, ARRAY_BITS - 1);
        if (pick < 55) begin
          count = $urandom_range(1, 130);
        end else if (pick < 70) begin
          count = $urandom_range(0, 8);
        end else if (pick < 85) begin
          start = ARRAY_BITS - 1 - $urandom_range(0, 200);
          count = $urandom_range(0, 300);
        end else if (pick < 98) begin
          count = $urandom_range(64, 1100);
        end else begin
          count = $urandom_range(0, ARRAY_BITS);
        end
        op.bit_start = START_W'(start);
        op.bit_count = COUNT_W'(count);
      end
      send_item(op);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_ch.read_data !== oldest_result.read_data) begin
          $error("read_data: expected %h, actual %h",
                 oldest_result.read_data, out_ch.read_data);
          fail_count++;
        end
        if (out_ch.range_error !== oldest_result.range_error) begin
          $error("range_error: expected %b, actual %b",
                 oldest_result.range_error, out_ch.range_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (bitmap_words[i]) bitmap_words[i] = '0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = '0;
    in_ch.word_index = '0;
    in_ch.word_data  = '0;
    in_ch.bit_start  = '0;
    in_ch.bit_count  = '0;
    in_ch.func       = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_word_access();
    test_range_functions();
    test_range_limits();
    test_unused_action();
    test_random_mix(1750);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bfi_pkg.sv
hdl/bfi_in_if.sv
hdl/bfi_out_if.sv
hdl/bfi_ram.sv
hdl/bfi_ctrl.sv
hdl/bfi_datapath.sv
hdl/bit_range_fill_invert_unit.sv
dv/tb_bit_range_fill_invert_unit.sv
